### rtl/core/pbp_pkg.sv
package pbp_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int PAGE_ID_BITS_DEF = 32;
	localparam int PIN_BITS_DEF = 16;

	localparam logic [1:0] OP_FETCH = 2'd0;
	localparam logic [1:0] OP_UNPIN = 2'd1;
	localparam logic [1:0] OP_NEW   = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	localparam logic [3:0] ACT_HIT      = 4'd0;
	localparam logic [3:0] ACT_WB       = 4'd1;
	localparam logic [3:0] ACT_READ     = 4'd2;
	localparam logic [3:0] ACT_NEW      = 4'd3;
	localparam logic [3:0] ACT_NOFRAME  = 4'd4;
	localparam logic [3:0] ACT_UNPINNED = 4'd5;
	localparam logic [3:0] ACT_NOTRES   = 4'd6;
	localparam logic [3:0] ACT_DOUBLE   = 4'd7;
	localparam logic [3:0] ACT_FLUSHED  = 4'd8;
	localparam logic [3:0] ACT_OVERFLOW = 4'd9;

	// source codes for the output mux
	localparam logic [1:0] SRC_REQ  = 2'd0;
	localparam logic [1:0] SRC_HIT  = 2'd1;
	localparam logic [1:0] SRC_VIC  = 2'd2;
	localparam logic [1:0] SRC_SCAN = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // latch request
		logic scan_clr;   // restart frame scan
		logic scan_step;  // advance frame scan
		logic do_commit;  // apply fetch/unpin/new update
		logic do_evict;   // drop the victim found by the scan
		logic do_flclr;   // clear dirty of scanned frame
	} pbp_cmd_t;

	// status from the datapath
	typedef struct packed {
		logic scan_end;   // scan index at last frame
		logic hit;
		logic pin_zero;
		logic pin_max;
		logic unused_left;
		logic victim_ok;
		logic victim_dirty;
		logic cur_dirty;  // scanned frame valid and dirty
	} pbp_sts_t;

endpackage

### rtl/core/pbp_datapath.sv
module pbp_datapath #(
	parameter int FRAMES = pbp_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = pbp_pkg::PAGE_ID_BITS_DEF,
	parameter int PIN_BITS = pbp_pkg::PIN_BITS_DEF,
	localparam int FB = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pbp_pkg::pbp_cmd_t       cmd,
	output pbp_pkg::pbp_sts_t       sts,
	input  logic [1:0]              in_op,
	input  logic [31:0]             in_page,
	input  logic                    in_dirty,
	output logic [1:0]              op_q,
	output logic [FB-1:0]           hit_frame,
	output logic [FB-1:0]           victim_frame,
	output logic [FB-1:0]           unused_frame,
	output logic [FB-1:0]           scan_frame,
	output logic [PAGE_ID_BITS-1:0] req_page,
	output logic [PAGE_ID_BITS-1:0] victim_page,
	output logic [PAGE_ID_BITS-1:0] scan_page
);

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	logic [PAGE_ID_BITS-1:0] page_q [FRAMES];
	logic [FRAMES-1:0]       valid_q, dirty_q, inrep_q;
	logic [PIN_BITS-1:0]     pin_q [FRAMES];
	logic [FB-1:0]           rank_q [FRAMES];
	logic [FB:0]             next_unused_q;
	logic [PAGE_ID_BITS-1:0] page_req_q;
	logic                    dirty_req_q;
	logic [FB-1:0]           scan_q;
	logic                    hit_q;
	logic [FB-1:0]           hit_f_q;
	logic                    vic_q;
	logic [FB-1:0]           vic_f_q;
	logic [FB:0]             rep_cnt_q;
	logic [1:0]              op_q_r;

	logic [FB-1:0] tgt;
	logic          tgt_rm, tgt_ins, tgt_new;

	assign op_q         = op_q_r;
	assign req_page     = page_req_q;
	assign hit_frame    = hit_f_q;
	assign victim_frame = vic_f_q;
	assign unused_frame = next_unused_q[FB-1:0];
	assign scan_frame   = scan_q;
	assign victim_page  = page_q[vic_f_q];
	assign scan_page    = page_q[scan_q];

	always_comb begin
		sts.scan_end     = (scan_q == FB'(FRAMES - 1));
		sts.hit          = hit_q;
		sts.pin_zero     = (pin_q[hit_f_q] == '0);
		sts.pin_max      = (pin_q[hit_f_q] == PIN_MAX);
		sts.unused_left  = (next_unused_q < (FB+1)'(FRAMES));
		sts.victim_ok    = vic_q;
		sts.victim_dirty = valid_q[vic_f_q] && dirty_q[vic_f_q];
		sts.cur_dirty    = valid_q[scan_q] && dirty_q[scan_q];
	end

	// decide which frame the commit touches and its replacer move
	always_comb begin
		tgt = hit_f_q;
		tgt_rm = 1'b0;
		tgt_ins = 1'b0;
		tgt_new = 1'b0;
		if (hit_q) begin
			if (op_q_r == pbp_pkg::OP_UNPIN)
				tgt_ins = (pin_q[hit_f_q] == PIN_BITS'(1));
			else
				tgt_rm = (pin_q[hit_f_q] == '0);
		end else begin
			tgt_new = 1'b1;
			tgt = sts.unused_left ? next_unused_q[FB-1:0] : vic_f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			inrep_q <= '0;
			next_unused_q <= '0;
			rep_cnt_q <= '0;
			op_q_r <= '0;
			page_req_q <= '0;
			dirty_req_q <= 1'b0;
			scan_q <= '0;
			hit_q <= 1'b0;
			hit_f_q <= '0;
			vic_q <= 1'b0;
			vic_f_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				page_q[i] <= '0;
				pin_q[i] <= '0;
				rank_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				op_q_r <= in_op;
				page_req_q <= PAGE_ID_BITS'(in_page);
				dirty_req_q <= in_dirty;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
				hit_q <= 1'b0;
				vic_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// one frame per cycle while scan_step is high: match and oldest-unpinned search
				if (valid_q[scan_q] && page_q[scan_q] == page_req_q && !hit_q) begin
					hit_q <= 1'b1;
					hit_f_q <= scan_q;
				end
				if (inrep_q[scan_q] && rank_q[scan_q] == '0 && !vic_q) begin
					vic_q <= 1'b1;
					vic_f_q <= scan_q;
				end
				if (!sts.scan_end)
					scan_q <= scan_q + FB'(1);
			end
			if (cmd.do_flclr)
				dirty_q[scan_q] <= 1'b0;
			// eviction always rides with the commit, which rewrites valid and dirty
			if (cmd.do_evict) begin
				for (int j = 0; j < FRAMES; j++)
					if (inrep_q[j] && rank_q[j] > rank_q[vic_f_q])
						rank_q[j] <= rank_q[j] - FB'(1);
				inrep_q[vic_f_q] <= 1'b0;
				rank_q[vic_f_q] <= '0;
				rep_cnt_q <= rep_cnt_q - (FB+1)'(1);
			end
			if (cmd.do_commit) begin
				if (tgt_new) begin
					if (sts.unused_left)
						next_unused_q <= next_unused_q + (FB+1)'(1);
					page_q[tgt] <= page_req_q;
					valid_q[tgt] <= 1'b1;
					pin_q[tgt] <= PIN_BITS'(1);
					dirty_q[tgt] <= (op_q_r == pbp_pkg::OP_NEW);
				end else if (op_q_r == pbp_pkg::OP_UNPIN) begin
					if (dirty_req_q)
						dirty_q[tgt] <= 1'b1;
					pin_q[tgt] <= pin_q[tgt] - PIN_BITS'(1);
					if (tgt_ins) begin
						inrep_q[tgt] <= 1'b1;
						rank_q[tgt] <= rep_cnt_q[FB-1:0];
						rep_cnt_q <= rep_cnt_q + (FB+1)'(1);
					end
				end else begin
					pin_q[tgt] <= pin_q[tgt] + PIN_BITS'(1);
					if (op_q_r == pbp_pkg::OP_NEW)
						dirty_q[tgt] <= 1'b1;
					if (tgt_rm) begin
						for (int j = 0; j < FRAMES; j++)
							if (inrep_q[j] && rank_q[j] > rank_q[tgt])
								rank_q[j] <= rank_q[j] - FB'(1);
						inrep_q[tgt] <= 1'b0;
						rank_q[tgt] <= '0;
						rep_cnt_q <= rep_cnt_q - (FB+1)'(1);
					end
				end
			end
		end
	end

endmodule

### rtl/core/pbp_ctrl.sv
module pbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_op,
	input  logic [1:0]        op_q,
	input  pbp_pkg::pbp_sts_t sts,
	output pbp_pkg::pbp_cmd_t cmd,
	output logic              out_load,
	output logic [3:0]        out_sel_act,
	output logic [1:0]        out_sel_src,
	output logic              out_sel_last,
	input  logic              out_free
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_FINAL  = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;
	localparam logic [2:0] ST_FLEND  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       wb_done_q;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_load = 1'b0;
		out_sel_act = pbp_pkg::ACT_HIT;
		out_sel_src = pbp_pkg::SRC_REQ;
		out_sel_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = (req_op == pbp_pkg::OP_FLUSH) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// evict path: write back a dirty victim first
				if (!sts.hit && op_q != pbp_pkg::OP_UNPIN && !sts.unused_left
						&& sts.victim_ok && sts.victim_dirty && !wb_done_q) begin
					if (out_free) begin
						out_load = 1'b1;
						out_sel_act = pbp_pkg::ACT_WB;
						out_sel_src = pbp_pkg::SRC_VIC;
						out_sel_last = 1'b0;
					end
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
					if (op_q == pbp_pkg::OP_UNPIN) begin
						if (!sts.hit) begin
							out_sel_act = pbp_pkg::ACT_NOTRES;
						end else if (sts.pin_zero) begin
							out_sel_act = pbp_pkg::ACT_DOUBLE;
							out_sel_src = pbp_pkg::SRC_HIT;
						end else begin
							out_sel_act = pbp_pkg::ACT_UNPINNED;
							out_sel_src = pbp_pkg::SRC_HIT;
							cmd.do_commit = 1'b1;
						end
					end else if (sts.hit) begin
						out_sel_src = pbp_pkg::SRC_HIT;
						if (sts.pin_max) begin
							out_sel_act = pbp_pkg::ACT_OVERFLOW;
						end else begin
							cmd.do_commit = 1'b1;
							out_sel_act = (op_q == pbp_pkg::OP_NEW) ?
								pbp_pkg::ACT_NEW : pbp_pkg::ACT_READ;
							if (op_q != pbp_pkg::OP_NEW)
								out_sel_act = pbp_pkg::ACT_HIT;
						end
					end else if (!sts.unused_left && !sts.victim_ok) begin
						out_sel_act = pbp_pkg::ACT_NOFRAME;
					end else begin
						cmd.do_commit = 1'b1;
						// drop the victim together with the final result
						cmd.do_evict = !sts.unused_left;
						out_sel_src = sts.unused_left ? pbp_pkg::SRC_REQ : pbp_pkg::SRC_VIC;
						out_sel_act = (op_q == pbp_pkg::OP_NEW) ?
							pbp_pkg::ACT_NEW : pbp_pkg::ACT_READ;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.cur_dirty) begin
					if (out_free) begin
						out_load = 1'b1;
						out_sel_act = pbp_pkg::ACT_WB;
						out_sel_src = pbp_pkg::SRC_SCAN;
						out_sel_last = 1'b0;
						cmd.do_flclr = 1'b1;
					end
				end else begin
					cmd.scan_step = 1'b1;
					if (sts.scan_end)
						state_d = ST_FLEND;
				end
			end
			ST_FLEND: begin
				if (out_free) begin
					out_load = 1'b1;
					out_sel_act = pbp_pkg::ACT_FLUSHED;
					out_sel_src = pbp_pkg::SRC_SCAN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wb_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				wb_done_q <= 1'b0;
			else if (state_q == ST_DECIDE && out_load)
				wb_done_q <= 1'b1;
		end
	end

endmodule

### rtl/core/page_buffer_pool_lru.sv
// Channel  Dir  Payload
// s_axis   in   tdata: operation[1:0], page_id[33:2], mark_dirty[34]
// m_axis   out  tdata: action[3:0], frame[7:4], result_page[39:8]; tlast: last
//
// Each request walks all frames one per cycle, then decides and
// answers; a dirty eviction first sends a write-back. A flush walks
// all frames, sends a write-back per dirty frame, then a flushed result.
// Reset clears all frame state at once. A stalled m_axis holds the
// controller in place; one result register parts the two sides.
module page_buffer_pool_lru #(
	parameter int FRAMES = pbp_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = pbp_pkg::PAGE_ID_BITS_DEF,
	parameter int PIN_BITS = pbp_pkg::PIN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // operation, page_id, mark_dirty
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // action, frame, result_page
	output logic        m_axis_tlast
);

	localparam int FB = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	pbp_pkg::pbp_cmd_t cmd;
	pbp_pkg::pbp_sts_t sts;
	logic [1:0] op_q;
	logic [FB-1:0] hit_f, vic_f, unu_f, scan_f;
	logic [PAGE_ID_BITS-1:0] req_pg, vic_pg, scan_pg;
	logic out_load, out_last, out_free;
	logic [3:0] out_act;
	logic [1:0] out_src;
	logic [3:0] act_q;
	logic [3:0] frame_q;
	logic [31:0] page_q;
	logic valid_q, last_q;
	logic [FB-1:0] fsel;
	logic [PAGE_ID_BITS-1:0] psel;

	assign out_free = !valid_q || m_axis_tready;

	pbp_ctrl u_ctrl (
		.clk, .arst_n,
		.req_valid(s_axis_tvalid), .req_ready(s_axis_tready),
		.req_op(s_axis_tdata[1:0]), .op_q, .sts, .cmd,
		.out_load, .out_sel_act(out_act), .out_sel_src(out_src),
		.out_sel_last(out_last), .out_free
	);

	pbp_datapath #(.FRAMES(FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS), .PIN_BITS(PIN_BITS))
	u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_op(s_axis_tdata[1:0]), .in_page(s_axis_tdata[33:2]),
		.in_dirty(s_axis_tdata[34]), .op_q,
		.hit_frame(hit_f), .victim_frame(vic_f), .unused_frame(unu_f),
		.scan_frame(scan_f), .req_page(req_pg), .victim_page(vic_pg),
		.scan_page(scan_pg)
	);

	always_comb begin
		fsel = '0;
		psel = req_pg;
		unique case (out_src)
			pbp_pkg::SRC_REQ: begin fsel = unu_f; psel = req_pg; end
			pbp_pkg::SRC_HIT: begin fsel = hit_f; psel = req_pg; end
			pbp_pkg::SRC_VIC: begin
				fsel = vic_f;
				psel = (out_act == pbp_pkg::ACT_WB) ? vic_pg : req_pg;
			end
			default: begin fsel = scan_f; psel = scan_pg; end
		endcase
		if (out_act == pbp_pkg::ACT_NOTRES || out_act == pbp_pkg::ACT_NOFRAME)
			fsel = '0;
		if (out_act == pbp_pkg::ACT_FLUSHED) begin
			fsel = '0;
			psel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			act_q <= out_act;
			frame_q <= 4'(fsel);
			page_q <= 32'(psel);
			last_q <= out_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {page_q, frame_q, act_q};
	assign m_axis_tlast = last_q;

endmodule

### rtl/core/pbp_checker.sv
module pbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("took two requests back to back");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] == pbp_pkg::ACT_FLUSHED |-> m_axis_tlast)
		else $error("flush done without last");

	a_wb_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] == pbp_pkg::ACT_WB |-> !m_axis_tlast)
		else $error("write back marked last");

endmodule

bind page_buffer_pool_lru pbp_checker u_pbp_checker (.*);
